>>> sv/rrts_pkg.sv
// Shared constants and types for the round-robin task scheduler.
// Used by round_robin_task_scheduler; no dependencies.
package rrts_pkg;

    localparam int TASK_SLOTS_DEF = 8;

    // Command codes
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_YIELD = 2'd2;
    localparam logic [1:0] CMD_DELAY = 2'd3;

    // Slot state codes
    localparam logic [1:0] ST_UNUSED  = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_READY   = 2'd2;
    localparam logic [1:0] ST_WAITING = 2'd3;

    // One slot table entry as held in the RAM
    typedef struct packed {
        logic [1:0]  state;
        logic [31:0] count;
    } entry_t;

endpackage

>>> sv/round_robin_task_scheduler.sv
// Round-robin task scheduler: slot table in one RAM, swept one slot a cycle.
// One command in flight at a time; the next is accepted the cycle after the word
// is loaded into the output register, where a finished word waits.
// Reset (async, rst_n low): all slots unused, idle task current; per-entry valid
// flops stand in for clearing the RAM, so no clearing pass is needed.
// Depends on rrts_pkg and rrts_ram.
module round_robin_task_scheduler #(
    parameter int TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic [1:0]  command,
    input  logic [31:0] delay_ticks,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [3:0]  next_task,
    output logic        idle_selected,
    output logic [2:0]  added_slot,
    output logic        table_full
);

    localparam int SLOT_W  = $clog2(TASK_SLOTS);
    localparam int TASK_W  = $clog2(TASK_SLOTS + 1);
    localparam int ENTRY_W = $bits(rrts_pkg::entry_t);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ADD    = 4'd1;
    localparam logic [3:0] S_TICK   = 4'd2;
    localparam logic [3:0] S_DELAY  = 4'd3;
    localparam logic [3:0] S_PREP   = 4'd4;
    localparam logic [3:0] S_PCHK   = 4'd5;
    localparam logic [3:0] S_SEARCH = 4'd6;
    localparam logic [3:0] S_OUT    = 4'd7;

    localparam logic [TASK_W-1:0] IDLE_ID   = TASK_W'(TASK_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

    logic [3:0]         state_reg, state_next;
    logic [TASK_W-1:0]  cnt_reg, cnt_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic [31:0]        ticks_reg, ticks_next;
    logic [TASK_W-1:0]  cur_reg, cur_next;
    logic [SLOT_W-1:0]  added_reg, added_next;
    logic               full_reg, full_next;
    logic               res_valid_reg, res_valid_next;
    logic [3:0]         next_task_reg, next_task_next;
    logic               idle_sel_reg, idle_sel_next;
    logic [2:0]         added_slot_reg, added_slot_next;
    logic               table_full_reg, table_full_next;
    logic [TASK_SLOTS-1:0] valid_reg, valid_next;
    logic               rd_vld_reg;
    logic [SLOT_W-1:0]  rd_addr_reg;

    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    rrts_pkg::entry_t   wr_ent;
    logic [SLOT_W-1:0]  rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    rrts_pkg::entry_t   rd_ent;
    logic [31:0]        dec_count;
    logic               cur_is_slot;
    logic [SLOT_W-1:0]  cur_slot;
    logic               have_data;
    logic               last_cnt;
    logic [31:0]        cur_ext;
    logic [31:0]        added_ext;

    rrts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TASK_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_ent),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Entries never written read as unused with a zero count
    assign rd_ent      = rd_vld_reg ? rrts_pkg::entry_t'(rd_data) : '0;
    assign dec_count   = rd_ent.count - 32'd1;
    assign cur_is_slot = (cur_reg < IDLE_ID);
    assign cur_slot    = cur_reg[SLOT_W-1:0];
    assign have_data   = (cnt_reg != '0);
    assign last_cnt    = (cnt_reg == TASK_W'(TASK_SLOTS));
    assign cur_ext     = 32'(cur_reg);
    assign added_ext   = 32'(added_reg);

    assign cmd_ready     = (state_reg == S_IDLE);
    assign res_valid     = res_valid_reg;
    assign next_task     = next_task_reg;
    assign idle_selected = idle_sel_reg;
    assign added_slot    = added_slot_reg;
    assign table_full    = table_full_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        ticks_next      = ticks_reg;
        cur_next        = cur_reg;
        added_next      = added_reg;
        full_next       = full_reg;
        res_valid_next  = res_valid_reg;
        next_task_next  = next_task_reg;
        idle_sel_next   = idle_sel_reg;
        added_slot_next = added_slot_reg;
        table_full_next = table_full_reg;
        valid_next      = valid_reg;
        wr_en           = 1'b0;
        wr_addr         = rd_addr_reg;
        wr_ent          = rd_ent;
        rd_addr         = idx_reg;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ticks_next = delay_ticks;
                    added_next = '0;
                    full_next  = 1'b0;
                    cnt_next   = '0;
                    idx_next   = '0;
                    unique case (command)
                        rrts_pkg::CMD_ADD:   state_next = S_ADD;
                        rrts_pkg::CMD_TICK:  state_next = S_TICK;
                        rrts_pkg::CMD_YIELD: state_next = S_PREP;
                        rrts_pkg::CMD_DELAY: state_next = S_DELAY;
                        default:             state_next = S_PREP;
                    endcase
                end
            end

            S_ADD:
            begin
                if (!last_cnt)
                begin
                    idx_next = (idx_reg == LAST_SLOT) ? '0 : idx_reg + 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                if (have_data && rd_ent.state == rrts_pkg::ST_UNUSED)
                begin
                    wr_en        = 1'b1;
                    wr_ent.state = rrts_pkg::ST_READY;
                    wr_ent.count = '0;
                    added_next   = rd_addr_reg;
                    state_next   = S_OUT;
                end
                else if (last_cnt)
                begin
                    full_next  = 1'b1;
                    state_next = S_OUT;
                end
            end

            S_TICK:
            begin
                if (!last_cnt)
                begin
                    idx_next = (idx_reg == LAST_SLOT) ? '0 : idx_reg + 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                // Count down waiting slots; wake on zero
                if (have_data && rd_ent.state == rrts_pkg::ST_WAITING)
                begin
                    wr_en        = 1'b1;
                    wr_ent.count = dec_count;
                    wr_ent.state = (dec_count == '0) ? rrts_pkg::ST_READY
                                                     : rrts_pkg::ST_WAITING;
                end
                if (last_cnt)
                begin
                    state_next = S_PREP;
                end
            end

            S_DELAY:
            begin
                if (cur_is_slot)
                begin
                    wr_en        = 1'b1;
                    wr_addr      = cur_slot;
                    wr_ent.count = ticks_reg;
                    wr_ent.state = (ticks_reg == '0) ? rrts_pkg::ST_READY
                                                     : rrts_pkg::ST_WAITING;
                end
                state_next = S_PREP;
            end

            S_PREP:
            begin
                rd_addr    = cur_slot;
                state_next = S_PCHK;
            end

            S_PCHK:
            begin
                // Demote a running current task, then search from the slot after it
                if (cur_is_slot && rd_ent.state == rrts_pkg::ST_RUNNING)
                begin
                    wr_en        = 1'b1;
                    wr_ent.state = rrts_pkg::ST_READY;
                end
                if (cur_is_slot && cur_slot != LAST_SLOT)
                begin
                    idx_next = cur_slot + 1'b1;
                end
                else
                begin
                    idx_next = '0;
                end
                cnt_next   = '0;
                state_next = S_SEARCH;
            end

            S_SEARCH:
            begin
                if (!last_cnt)
                begin
                    idx_next = (idx_reg == LAST_SLOT) ? '0 : idx_reg + 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                if (have_data && rd_ent.state == rrts_pkg::ST_READY)
                begin
                    wr_en        = 1'b1;
                    wr_ent.state = rrts_pkg::ST_RUNNING;
                    cur_next     = TASK_W'(rd_addr_reg);
                    state_next   = S_OUT;
                end
                else if (last_cnt)
                begin
                    cur_next   = IDLE_ID;
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                // Hold until the output register is free
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next  = 1'b1;
                    next_task_next  = cur_ext[3:0];
                    idle_sel_next   = !cur_is_slot;
                    added_slot_next = added_ext[2:0];
                    table_full_next = full_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= IDLE_ID;
            valid_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            valid_reg     <= valid_next;
            rd_vld_reg    <= valid_reg[rd_addr];
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg        <= cnt_next;
        idx_reg        <= idx_next;
        ticks_reg      <= ticks_next;
        added_reg      <= added_next;
        full_reg       <= full_next;
        next_task_reg  <= next_task_next;
        idle_sel_reg   <= idle_sel_next;
        added_slot_reg <= added_slot_next;
        table_full_reg <= table_full_next;
        rd_addr_reg    <= rd_addr;
    end

endmodule

>>> sv/rrts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rrts_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for round_robin_task_scheduler: directed table plus random commands.
// Checks results with typed rows or an in-bench model; depends on rrts_pkg and the RTL.
module tb_top;

    localparam int SLOTS = rrts_pkg::TASK_SLOTS_DEF;
    localparam logic [3:0] IDLE_IDX = 4'(SLOTS);
    localparam int RAND_ITEMS = 1300;
    localparam int DIR_ROWS = 25;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 6;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [3:0] next_task;
        logic       idle_selected;
        logic [2:0] added_slot;
        logic       table_full;
    } sched_word_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] ticks;
        logic        typed;
        sched_word_t exp;
    } cmd_row_t;

    typedef enum logic [2:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT, RX_BLOCKS} rx_mode_e;

    localparam sched_word_t NO_EXP = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    logic [1:0]  command = rrts_pkg::CMD_ADD;
    logic [31:0] delay_ticks = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [3:0]  next_task;
    logic        idle_selected;
    logic [2:0]  added_slot;
    logic        table_full;

    // scheduler model state
    logic [1:0]  slot_st [SLOTS];
    logic [31:0] slot_cnt [SLOTS];
    int unsigned cur_task;
    logic [1:0]  idle_st;

    sched_word_t sched_words_q [$];
    cmd_row_t    directed_rows [DIR_ROWS];
    int          fail_count = 0;
    int          words_checked = 0;
    int          idle_picks = 0;
    int          full_reports = 0;
    int          cmd_count [4] = '{0, 0, 0, 0};
    int          burst_left = 0;
    rx_mode_e    rx_mode = RX_OPEN;
    int          rx_phase_left = 0;
    int unsigned rx_cycle = 0;

    round_robin_task_scheduler #(.TASK_SLOTS(SLOTS)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .command      (command),
        .delay_ticks  (delay_ticks),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .next_task    (next_task),
        .idle_selected(idle_selected),
        .added_slot   (added_slot),
        .table_full   (table_full)
    );

    always #5 clk = ~clk;

    task automatic reschedule();
        int unsigned start_idx;
        int unsigned idx;
        int unsigned found;
        found = SLOTS;
        if (cur_task < SLOTS)
        begin
            if (slot_st[cur_task] == rrts_pkg::ST_RUNNING)
                slot_st[cur_task] = rrts_pkg::ST_READY;
            start_idx = cur_task + 1;
        end
        else
        begin
            if (idle_st == rrts_pkg::ST_RUNNING)
                idle_st = rrts_pkg::ST_READY;
            start_idx = 0;
        end
        // current slot comes up last in the sweep
        for (int k = 0; k < SLOTS; k++)
        begin
            idx = (start_idx + k) % SLOTS;
            if (found == SLOTS && slot_st[idx] == rrts_pkg::ST_READY)
                found = idx;
        end
        cur_task = found;
        if (found < SLOTS)
        begin
            slot_st[found] = rrts_pkg::ST_RUNNING;
            idle_st = rrts_pkg::ST_READY;
        end
        else
            idle_st = rrts_pkg::ST_RUNNING;
    endtask

    task automatic schedule_command(input logic [1:0] cmd, input logic [31:0] ticks,
                                    output sched_word_t res);
        int unsigned pos;
        logic [2:0]  added;
        logic        full;
        added = '0;
        full = 1'b0;
        case (cmd)
            rrts_pkg::CMD_ADD:
            begin
                pos = SLOTS;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (slot_st[i] == rrts_pkg::ST_UNUSED)
                        pos = i;
                if (pos < SLOTS)
                begin
                    slot_st[pos] = rrts_pkg::ST_READY;
                    slot_cnt[pos] = '0;
                    added = 3'(pos);
                end
                else
                    full = 1'b1;
            end
            rrts_pkg::CMD_TICK:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (slot_st[i] == rrts_pkg::ST_WAITING)
                    begin
                        slot_cnt[i] = slot_cnt[i] - 32'd1;
                        if (slot_cnt[i] == '0)
                            slot_st[i] = rrts_pkg::ST_READY;
                    end
                reschedule();
            end
            rrts_pkg::CMD_YIELD:
                reschedule();
            rrts_pkg::CMD_DELAY:
            begin
                // the idle task cannot wait: only reschedule
                if (cur_task < SLOTS)
                begin
                    slot_cnt[cur_task] = ticks;
                    slot_st[cur_task] = (ticks == '0) ? rrts_pkg::ST_READY
                                                      : rrts_pkg::ST_WAITING;
                end
                reschedule();
            end
        endcase
        res.next_task = 4'(cur_task);
        res.idle_selected = (cur_task >= SLOTS);
        res.added_slot = added;
        res.table_full = full;
    endtask

    // Drive one command word and hold it until accepted; the payload for a
    // following word in the same burst goes out on the accepting edge.
    task automatic send_word(input logic [1:0] cmd, input logic [31:0] ticks,
                             input logic typed, input sched_word_t exp);
        sched_word_t pred;
        cmd_valid <= 1'b1;
        command <= cmd;
        delay_ticks <= ticks;
        do
            @(posedge clk);
        while (!cmd_ready);
        schedule_command(cmd, ticks, pred);
        sched_words_q.push_back(typed ? exp : pred);
        cmd_count[cmd]++;
        if (burst_left == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            // long bursts now and then leave stretches without gaps
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
        end
        else
            burst_left--;
    endtask

    initial
    begin
        logic [1:0]  rcmd;
        logic [31:0] rticks;
        int unsigned pick;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_st[i] = rrts_pkg::ST_UNUSED;
            slot_cnt[i] = '0;
        end
        cur_task = SLOTS;
        idle_st = rrts_pkg::ST_RUNNING;

        directed_rows = '{
            '{rrts_pkg::CMD_YIELD, 32'd0,         1'b1, '{IDLE_IDX, 1'b1, 3'd0, 1'b0}},
            '{rrts_pkg::CMD_TICK,  32'd0,         1'b1, '{IDLE_IDX, 1'b1, 3'd0, 1'b0}},
            '{rrts_pkg::CMD_DELAY, 32'hFFFF_FFFF, 1'b1, '{IDLE_IDX, 1'b1, 3'd0, 1'b0}},
            '{rrts_pkg::CMD_ADD,   32'd0,         1'b1, '{IDLE_IDX, 1'b1, 3'd0, 1'b0}},
            '{rrts_pkg::CMD_ADD,   32'hFFFF_FFFF, 1'b1, '{IDLE_IDX, 1'b1, 3'd1, 1'b0}},
            '{rrts_pkg::CMD_ADD,   32'd0,         1'b1, '{IDLE_IDX, 1'b1, 3'd2, 1'b0}},
            '{rrts_pkg::CMD_ADD,   32'd0,         1'b1, '{IDLE_IDX, 1'b1, 3'd3, 1'b0}},
            '{rrts_pkg::CMD_ADD,   32'd0,         1'b1, '{IDLE_IDX, 1'b1, 3'd4, 1'b0}},
            '{rrts_pkg::CMD_ADD,   32'd0,         1'b1, '{IDLE_IDX, 1'b1, 3'd5, 1'b0}},
            '{rrts_pkg::CMD_ADD,   32'd0,         1'b1, '{IDLE_IDX, 1'b1, 3'd6, 1'b0}},
            '{rrts_pkg::CMD_ADD,   32'd0,         1'b1, '{IDLE_IDX, 1'b1, 3'd7, 1'b0}},
            '{rrts_pkg::CMD_ADD,   32'd0,         1'b1, '{IDLE_IDX, 1'b1, 3'd0, 1'b1}},
            '{rrts_pkg::CMD_YIELD, 32'd0,         1'b0, NO_EXP},
            '{rrts_pkg::CMD_DELAY, 32'd0,         1'b0, NO_EXP},
            '{rrts_pkg::CMD_DELAY, 32'hFFFF_FFFF, 1'b0, NO_EXP},
            '{rrts_pkg::CMD_DELAY, 32'd1,         1'b0, NO_EXP},
            '{rrts_pkg::CMD_TICK,  32'hFFFF_FFFF, 1'b0, NO_EXP},
            '{rrts_pkg::CMD_DELAY, 32'd2,         1'b0, NO_EXP},
            '{rrts_pkg::CMD_DELAY, 32'd3,         1'b0, NO_EXP},
            '{rrts_pkg::CMD_DELAY, 32'd1,         1'b0, NO_EXP},
            '{rrts_pkg::CMD_DELAY, 32'd1,         1'b0, NO_EXP},
            '{rrts_pkg::CMD_TICK,  32'd0,         1'b0, NO_EXP},
            '{rrts_pkg::CMD_YIELD, 32'd0,         1'b0, NO_EXP},
            '{rrts_pkg::CMD_ADD,   32'd0,         1'b0, NO_EXP},
            '{rrts_pkg::CMD_TICK,  32'd0,         1'b0, NO_EXP}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_word(directed_rows[i].cmd, directed_rows[i].ticks,
                      directed_rows[i].typed, directed_rows[i].exp);

        repeat (RAND_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                rcmd = rrts_pkg::CMD_ADD;
            else if (pick < 45)
                rcmd = rrts_pkg::CMD_TICK;
            else if (pick < 65)
                rcmd = rrts_pkg::CMD_YIELD;
            else
                rcmd = rrts_pkg::CMD_DELAY;
            rticks = $urandom;
            // keep most delays short so slots keep cycling back to ready
            if (rcmd == rrts_pkg::CMD_DELAY)
            begin
                pick = $urandom_range(0, 199);
                if (pick < 170)
                    rticks = $urandom_range(0, 6);
                else if (pick < 198)
                    rticks = $urandom_range(7, 30);
            end
            send_word(rcmd, rticks, 1'b0, NO_EXP);
        end
        cmd_valid <= 1'b0;

        while (sched_words_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d commands: add %0d, tick %0d, yield %0d, delay %0d; %0d words checked",
                 cmd_count[rrts_pkg::CMD_ADD] + cmd_count[rrts_pkg::CMD_TICK]
                 + cmd_count[rrts_pkg::CMD_YIELD] + cmd_count[rrts_pkg::CMD_DELAY],
                 cmd_count[rrts_pkg::CMD_ADD], cmd_count[rrts_pkg::CMD_TICK],
                 cmd_count[rrts_pkg::CMD_YIELD], cmd_count[rrts_pkg::CMD_DELAY],
                 words_checked);
        $display("Idle task picked %0d times, full table seen %0d times",
                 idle_picks, full_reports);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // result side back-pressure: switch between stall patterns every so often
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_phase_left == 0)
        begin
            rx_mode <= rx_mode_e'($urandom_range(0, 4));
            rx_phase_left <= $urandom_range(40, 200);
        end
        else
            rx_phase_left <= rx_phase_left - 1;
        case (rx_mode)
            RX_OPEN:   res_ready <= 1'b1;
            RX_COIN:   res_ready <= $urandom_range(0, 1);
            RX_SPARSE: res_ready <= ($urandom_range(0, 3) == 0);
            RX_BEAT:   res_ready <= (rx_cycle[1:0] != 2'd3);
            default:   res_ready <= (rx_cycle[3:0] < 4'd10);
        endcase
    end

    always @(posedge clk)
    begin
        sched_word_t exp;
        if (rst_n && res_valid && res_ready)
        begin
            if (sched_words_q.size() == 0)
            begin
                $error("unexpected result word: next_task %0d", next_task);
                fail_count++;
            end
            else
            begin
                exp = sched_words_q.pop_front();
                words_checked++;
                if (idle_selected)
                    idle_picks++;
                if (table_full)
                    full_reports++;
                if (next_task !== exp.next_task)
                begin
                    $error("next_task: expected %0d, got %0d", exp.next_task, next_task);
                    fail_count++;
                end
                if (idle_selected !== exp.idle_selected)
                begin
                    $error("idle_selected: expected %0d, got %0d",
                           exp.idle_selected, idle_selected);
                    fail_count++;
                end
                if (added_slot !== exp.added_slot)
                begin
                    $error("added_slot: expected %0d, got %0d", exp.added_slot, added_slot);
                    fail_count++;
                end
                if (table_full !== exp.table_full)
                begin
                    $error("table_full: expected %0d, got %0d", exp.table_full, table_full);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: give up after a long run of cycles with no handshake
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
sv/rrts_pkg.sv
sv/rrts_ram.sv
sv/round_robin_task_scheduler.sv
bench/tb_top.sv
